@@ hdl/hdtmc_pkg.sv @@
package hdtmc_pkg;

  localparam int unsigned MaxParticles = 4096;
  localparam int unsigned PosFracBits  = 16;

  localparam int unsigned IdxW   = $clog2(MaxParticles);
  localparam int unsigned PidW   = 12;
  localparam int unsigned PinW   = 13;
  localparam int unsigned PosW   = 24;
  localparam int unsigned BoxW   = 24;
  localparam int unsigned StepW  = 17;
  localparam int unsigned DistW  = 46;
  localparam int unsigned CfgW   = 46;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ActW   = 2;

  localparam int unsigned ProdW    = StepW + 1 + PosW;
  localparam int unsigned StepValW = ProdW - PosFracBits;
  localparam int unsigned TrialW   = ((StepValW > PosW) ? StepValW : PosW) + 1;
  localparam int unsigned DiffW    = TrialW + 2;
  localparam int unsigned SqW      = 2 * DiffW;
  localparam int unsigned SumW     = SqW + 1;
  localparam int unsigned BestW    = DistW + 1;
  localparam int unsigned MemW     = 2 * PosW;

  localparam logic [PinW-1:0]  MaxCount     = PinW'(MaxParticles);
  localparam logic [PinW-1:0]  PinReset     = 13'd4096;
  localparam logic [BoxW-1:0]  BoxReset     = 24'd9830400;
  localparam logic [StepW-1:0] StepReset    = 17'd32768;
  localparam logic [DistW-1:0] ContactReset = 46'd17179869184;

  typedef enum logic [CfgIdxW-1:0] {
    CfgParticles = 2'd0,
    CfgBox       = 2'd1,
    CfgStep      = 2'd2,
    CfgContact   = 2'd3
  } cfg_idx_e;

  typedef enum logic [ActW-1:0] {
    ActLoad  = 2'd0,
    ActTrial = 2'd1,
    ActRead  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StRdAddr,
    StRdData,
    StTrAddr,
    StTrData,
    StSweep,
    StDrain,
    StDecide,
    StDone
  } state_e;

  typedef struct packed {
    logic capture;
    logic res_load;
    logic res_rd;
    logic tx_load;
    logic sweep_start;
    logic issue;
    logic decide;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic pipe_busy;
  } sts_t;

  // Wraps a difference at most once by the box size, in each direction.
  function automatic logic signed [DiffW-1:0] wrap_once(input logic signed [DiffW-1:0] d,
                                                        input logic [BoxW-1:0] bs);
    logic signed [DiffW-1:0] bsd;
    logic signed [DiffW:0]   bs2;
    logic signed [DiffW:0]   d2;
    logic signed [DiffW-1:0] r;
    bsd = $signed({{(DiffW - BoxW){1'b0}}, bs});
    bs2 = $signed({{(DiffW + 1 - BoxW){1'b0}}, bs});
    r   = d;
    d2  = $signed({r, 1'b0});
    if (d2 > bs2) begin
      r = r - bsd;
    end
    d2 = $signed({r, 1'b0});
    if (d2 < -bs2) begin
      r = r + bsd;
    end
    return r;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] hi;
    logic signed [DiffW-1:0] lo;
    logic signed [PosW-1:0]  r;
    hi = $signed({{(DiffW - PosW + 1){1'b0}}, {(PosW - 1){1'b1}}});
    lo = $signed({{(DiffW - PosW + 1){1'b1}}, {(PosW - 1){1'b0}}});
    if (v > hi) begin
      r = hi[PosW-1:0];
    end else if (v < lo) begin
      r = lo[PosW-1:0];
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/hdtmc_ctrl.sv @@
module hdtmc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hdtmc_pkg::ActW-1:0]     action_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  hdtmc_pkg::sts_t                sts_i,
  output hdtmc_pkg::cmd_t                cmd_o
);

  hdtmc_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == hdtmc_pkg::StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hdtmc_pkg::StIdle: begin
        if (in_valid_i) begin
          unique case (hdtmc_pkg::action_e'(action_i))
            hdtmc_pkg::ActLoad:  state_d = hdtmc_pkg::StLoad;
            hdtmc_pkg::ActTrial: state_d = hdtmc_pkg::StTrAddr;
            default:             state_d = hdtmc_pkg::StRdAddr;
          endcase
        end
      end
      hdtmc_pkg::StLoad:   state_d = hdtmc_pkg::StDone;
      hdtmc_pkg::StRdAddr: state_d = hdtmc_pkg::StRdData;
      hdtmc_pkg::StRdData: state_d = hdtmc_pkg::StDone;
      hdtmc_pkg::StTrAddr: state_d = hdtmc_pkg::StTrData;
      hdtmc_pkg::StTrData: state_d = hdtmc_pkg::StSweep;
      hdtmc_pkg::StSweep: begin
        if (sts_i.sweep_done) begin
          state_d = hdtmc_pkg::StDrain;
        end
      end
      hdtmc_pkg::StDrain: begin
        if (!sts_i.pipe_busy) begin
          state_d = hdtmc_pkg::StDecide;
        end
      end
      hdtmc_pkg::StDecide: state_d = hdtmc_pkg::StDone;
      hdtmc_pkg::StDone: begin
        if (out_free) begin
          state_d = hdtmc_pkg::StIdle;
        end
      end
      default: state_d = hdtmc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      hdtmc_pkg::StLoad:   cmd_o.res_load = 1'b1;
      hdtmc_pkg::StRdData: cmd_o.res_rd = 1'b1;
      hdtmc_pkg::StTrData: begin
        cmd_o.res_rd      = 1'b1;
        cmd_o.tx_load     = 1'b1;
        cmd_o.sweep_start = 1'b1;
      end
      hdtmc_pkg::StSweep:  cmd_o.issue = !sts_i.sweep_done;
      hdtmc_pkg::StDecide: cmd_o.decide = 1'b1;
      hdtmc_pkg::StDone:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hdtmc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != hdtmc_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/hdtmc_dpath.sv @@
module hdtmc_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hdtmc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [hdtmc_pkg::CfgW-1:0]            cfg_data_i,
  input  logic [hdtmc_pkg::PidW-1:0]            particle_index_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     load_x_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     load_y_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     vel_x_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     vel_y_i,
  input  hdtmc_pkg::cmd_t                       cmd_i,
  output hdtmc_pkg::sts_t                       sts_o,
  output logic                                  accepted_o,
  output logic signed [hdtmc_pkg::PosW-1:0]     out_x_o,
  output logic signed [hdtmc_pkg::PosW-1:0]     out_y_o,
  output logic [hdtmc_pkg::DistW-1:0]           nearest_sq_dist_o
);

  localparam int unsigned PosW  = hdtmc_pkg::PosW;
  localparam int unsigned DiffW = hdtmc_pkg::DiffW;
  localparam int unsigned DistW = hdtmc_pkg::DistW;
  localparam int unsigned IdxW  = hdtmc_pkg::IdxW;

  // Configuration registers.
  logic [hdtmc_pkg::PinW-1:0]  pin_q;
  logic [hdtmc_pkg::BoxW-1:0]  box_q;
  logic [hdtmc_pkg::StepW-1:0] step_q;
  logic [DistW-1:0]            contact_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q     <= hdtmc_pkg::PinReset;
      box_q     <= hdtmc_pkg::BoxReset;
      step_q    <= hdtmc_pkg::StepReset;
      contact_q <= hdtmc_pkg::ContactReset;
    end else if (cfg_we_i) begin
      unique case (hdtmc_pkg::cfg_idx_e'(cfg_index_i))
        hdtmc_pkg::CfgParticles: pin_q     <= cfg_data_i[hdtmc_pkg::PinW-1:0];
        hdtmc_pkg::CfgBox:       box_q     <= cfg_data_i[hdtmc_pkg::BoxW-1:0];
        hdtmc_pkg::CfgStep:      step_q    <= cfg_data_i[hdtmc_pkg::StepW-1:0];
        hdtmc_pkg::CfgContact:   contact_q <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [IdxW-1:0]         idx_q;
  logic signed [PosW-1:0]  ld_x_q, ld_y_q, vel_x_q, vel_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q   <= particle_index_i[IdxW-1:0];
      ld_x_q  <= load_x_i;
      ld_y_q  <= load_y_i;
      vel_x_q <= vel_x_i;
      vel_y_q <= vel_y_i;
    end
  end

  // Position memory, x in the upper half of each word.
  logic [hdtmc_pkg::MemW-1:0] mem [hdtmc_pkg::MaxParticles];
  logic [hdtmc_pkg::MemW-1:0] rd_q;
  logic [hdtmc_pkg::MemW-1:0] wr_data;
  logic [IdxW-1:0]            rd_addr;
  logic                       mem_we;
  logic signed [PosW-1:0]     rd_x, rd_y;

  logic [hdtmc_pkg::PinW-1:0] cnt_q;
  logic [hdtmc_pkg::PinW-1:0] n_lim;
  logic                       acc_w;
  logic signed [PosW-1:0]     wt_x_q, wt_y_q;

  assign rd_addr = cmd_i.issue ? cnt_q[IdxW-1:0] : idx_q;
  assign mem_we  = cmd_i.res_load || (cmd_i.decide && acc_w);
  assign wr_data = cmd_i.res_load ? {ld_x_q, ld_y_q} : {wt_x_q, wt_y_q};
  assign rd_x    = $signed(rd_q[2*PosW-1:PosW]);
  assign rd_y    = $signed(rd_q[PosW-1:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Trial point.
  logic signed [hdtmc_pkg::ProdW-1:0]  prod_x_q, prod_y_q;
  logic signed [hdtmc_pkg::TrialW-1:0] tx_x_q, tx_y_q;

  always_ff @(posedge clk_i) begin
    prod_x_q <= $signed({1'b0, step_q}) * vel_x_q;
    prod_y_q <= $signed({1'b0, step_q}) * vel_y_q;
    if (cmd_i.tx_load) begin
      tx_x_q <= hdtmc_pkg::TrialW'(rd_x)
              + hdtmc_pkg::TrialW'($signed(prod_x_q[hdtmc_pkg::ProdW-1:hdtmc_pkg::PosFracBits]));
      tx_y_q <= hdtmc_pkg::TrialW'(rd_y)
              + hdtmc_pkg::TrialW'($signed(prod_y_q[hdtmc_pkg::ProdW-1:hdtmc_pkg::PosFracBits]));
    end
    wt_x_q <= hdtmc_pkg::sat_pos(hdtmc_pkg::wrap_once(DiffW'(tx_x_q), box_q));
    wt_y_q <= hdtmc_pkg::sat_pos(hdtmc_pkg::wrap_once(DiffW'(tx_y_q), box_q));
  end

  // Sweep counter.
  assign n_lim = (pin_q > hdtmc_pkg::MaxCount) ? hdtmc_pkg::MaxCount : pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep_start) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Distance pipeline: difference, wrap, square, then sum and minimum.
  logic                           v1_q, v2_q, v3_q, v4_q;
  logic signed [DiffW-1:0]        dx_q, dy_q, wx_q, wy_q;
  logic signed [hdtmc_pkg::SqW-1:0] sqx_q, sqy_q;
  logic [hdtmc_pkg::SumW-1:0]     sum;
  logic [hdtmc_pkg::BestW-1:0]    best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue && (cnt_q[IdxW-1:0] != idx_q);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign sum = hdtmc_pkg::SumW'($unsigned(sqx_q)) + hdtmc_pkg::SumW'($unsigned(sqy_q));

  always_ff @(posedge clk_i) begin
    dx_q  <= DiffW'(tx_x_q) - DiffW'(rd_x);
    dy_q  <= DiffW'(tx_y_q) - DiffW'(rd_y);
    wx_q  <= hdtmc_pkg::wrap_once(dx_q, box_q);
    wy_q  <= hdtmc_pkg::wrap_once(dy_q, box_q);
    sqx_q <= wx_q * wx_q;
    sqy_q <= wy_q * wy_q;
    if (cmd_i.sweep_start) begin
      best_q <= {1'b1, {DistW{1'b0}}};
    end else if (v4_q && (sum < hdtmc_pkg::SumW'(best_q))) begin
      best_q <= hdtmc_pkg::BestW'(sum);
    end
  end

  assign acc_w = best_q > {1'b0, contact_q};

  assign sts_o.sweep_done = (cnt_q >= n_lim);
  assign sts_o.pipe_busy  = v1_q || v2_q || v3_q || v4_q;

  // Result and output registers.
  logic                   res_acc_q;
  logic signed [PosW-1:0] res_x_q, res_y_q;
  logic [DistW-1:0]       res_near_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_acc_q  <= 1'b0;
      res_x_q    <= ld_x_q;
      res_y_q    <= ld_y_q;
      res_near_q <= '0;
    end else if (cmd_i.res_rd) begin
      res_acc_q  <= 1'b0;
      res_x_q    <= rd_x;
      res_y_q    <= rd_y;
      res_near_q <= '0;
    end else if (cmd_i.decide) begin
      res_near_q <= best_q[DistW] ? {DistW{1'b1}} : best_q[DistW-1:0];
      if (acc_w) begin
        res_acc_q <= 1'b1;
        res_x_q   <= wt_x_q;
        res_y_q   <= wt_y_q;
      end
    end
    if (cmd_i.out_load) begin
      accepted_o        <= res_acc_q;
      out_x_o           <= res_x_q;
      out_y_o           <= res_y_q;
      nearest_sq_dist_o <= res_near_q;
    end
  end

endmodule

@@ hdl/hard_disk_trial_move_checker_unit.sv @@
// Hard-disk trial-move checker for a periodic square box. Load, read and trial items are
// taken one at a time; a result waits in an output register while the next item is
// transferred. A trial move compares the trial point with every other particle in use,
// one position read from the position memory each cycle, followed by a short pipeline
// drain. Positions read before they were ever loaded are not defined.
module hard_disk_trial_move_checker_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hdtmc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [hdtmc_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [hdtmc_pkg::ActW-1:0]            action_i,
  input  logic [hdtmc_pkg::PidW-1:0]            particle_index_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     load_x_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     load_y_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     vel_x_i,
  input  logic signed [hdtmc_pkg::PosW-1:0]     vel_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  accepted_o,
  output logic signed [hdtmc_pkg::PosW-1:0]     out_x_o,
  output logic signed [hdtmc_pkg::PosW-1:0]     out_y_o,
  output logic [hdtmc_pkg::DistW-1:0]           nearest_sq_dist_o
);

  hdtmc_pkg::cmd_t cmd;
  hdtmc_pkg::sts_t sts;

  hdtmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hdtmc_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .particle_index_i  (particle_index_i),
    .load_x_i          (load_x_i),
    .load_y_i          (load_y_i),
    .vel_x_i           (vel_x_i),
    .vel_y_i           (vel_y_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .accepted_o        (accepted_o),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .nearest_sq_dist_o (nearest_sq_dist_o)
  );

endmodule
